// ----- rtl/sscp_pkg.sv -----
`timescale 1ns / 1ps

package sscp_pkg;

	// Payload bytes a frame may hold before it is dropped.
	localparam int unsigned MAX_PAYLOAD = 9;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned VAL_W       = 16;

	localparam logic [7:0] CH_E    = 8'h45;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NUL  = 8'h00;

	localparam logic [1:0] CMD_WORKING = 2'd0;
	localparam logic [1:0] CMD_STANDBY = 2'd1;
	localparam logic [1:0] CMD_MOTOR   = 2'd2;

	typedef enum logic [2:0] {
		KIND_P = 3'd0,
		KIND_F = 3'd1,
		KIND_W = 3'd2,
		KIND_S = 3'd3,
		KIND_M = 3'd4
	} kind_t;

	typedef struct packed {
		logic [CNT_W-1:0] byte_count;
		kind_t            frame_kind;
		logic [VAL_W-1:0] acc;
		logic             payload_ended;
	} frame_state_t;

	typedef struct packed {
		logic             valid;
		logic [1:0]       cmd_kind;
		logic [VAL_W-1:0] value;
	} result_t;

	localparam frame_state_t FRAME_IDLE = '{
		byte_count:    '0,
		frame_kind:    KIND_P,
		acc:           '0,
		payload_ended: 1'b0
	};

endpackage

// ----- rtl/sscp_if.sv -----
`timescale 1ns / 1ps

interface sscp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sscp_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd_kind;
	logic [15:0] value;

	modport source (output valid, output cmd_kind, output value, input ready);
	modport sink (input valid, input cmd_kind, input value, output ready);
endinterface

// ----- rtl/serial_setpoint_command_parser_core.sv -----
`timescale 1ns / 1ps

// Channel | Dir | Payload                         | Transfer
// rx      | in  | rx_byte[7:0]                    | valid & ready at rising clk
// cmd     | out | cmd_kind[1:0], value[15:0]      | valid & ready at rising clk
//
// Each byte goes from transfer to result through the input register and
// then through the frame step logic into the result register.
// A new byte is taken every cycle; only a finished command still waiting
// on cmd while the next byte also closes a frame holds off rx.
// arst_n clears the frame state and both valid flags; the block then idles.
// The payload accumulate (acc*10 + digit) sets the critical path.

module serial_setpoint_command_parser_core (
	input logic         clk,
	input logic         arst_n,
	sscp_byte_if.sink   rx,
	sscp_cmd_if.source  cmd
);
	import sscp_pkg::*;

	// input stage
	logic         valid_s1;
	logic [7:0]   rx_byte_s1;

	// frame state and result register
	frame_state_t state_q;
	frame_state_t state_nxt;
	result_t      step_res;
	logic         out_valid_q;
	logic [1:0]   cmd_kind_q;
	logic [15:0]  value_q;

	logic         advance;
	logic         out_free;

	sscp_step u_step (
		.rx_byte (rx_byte_s1),
		.st      (state_q),
		.nxt     (state_nxt),
		.res     (step_res)
	);

	// The result register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || cmd.ready;

	// Advance the held byte unless it closes a frame with nowhere to put the result.
	assign advance  = valid_s1 && (!step_res.valid || out_free);

	// Take a new byte when the input stage is empty or moves on.
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// Commit the frame state for every byte that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRAME_IDLE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Load a fresh command, drop the flag once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			cmd_kind_q <= step_res.cmd_kind;
			value_q    <= step_res.value;
		end
	end

	assign cmd.valid    = out_valid_q;
	assign cmd.cmd_kind = cmd_kind_q;
	assign cmd.value    = value_q;

endmodule

// ----- rtl/sscp_step.sv -----
`timescale 1ns / 1ps

module sscp_step (
	input  logic [7:0]           rx_byte,
	input  sscp_pkg::frame_state_t st,
	output sscp_pkg::frame_state_t nxt,
	output sscp_pkg::result_t      res
);
	import sscp_pkg::*;

	logic             is_letter;
	kind_t            letter_kind;
	logic [VAL_W-1:0] acc_times_ten;
	logic [VAL_W-1:0] digit;

	// acc*10 as two shifts and an add, wrapping at 16 bits
	assign acc_times_ten = {st.acc[VAL_W-4:0], 3'b000} + {st.acc[VAL_W-2:0], 1'b0};
	assign digit         = {{(VAL_W-8){1'b0}}, rx_byte} - {{(VAL_W-8){1'b0}}, CH_ZERO};

	always_comb begin
		is_letter   = 1'b1;
		letter_kind = KIND_P;
		case (rx_byte)
			CH_P: letter_kind = KIND_P;
			CH_F: letter_kind = KIND_F;
			CH_W: letter_kind = KIND_W;
			CH_S: letter_kind = KIND_S;
			CH_M: letter_kind = KIND_M;
			default: is_letter = 1'b0;
		endcase
	end

	always_comb begin
		nxt = st;
		res = '0;
		if (st.byte_count == '0) begin
			// open a frame on a type letter, drop anything else
			if (is_letter) begin
				nxt            = FRAME_IDLE;
				nxt.frame_kind = letter_kind;
				nxt.byte_count = CNT_W'(1);
			end
		end else if (rx_byte == CH_E) begin
			nxt = FRAME_IDLE;
			case (st.frame_kind)
				KIND_W: begin
					res.valid    = 1'b1;
					res.cmd_kind = CMD_WORKING;
					res.value    = st.acc;
				end
				KIND_S: begin
					res.valid    = 1'b1;
					res.cmd_kind = CMD_STANDBY;
					res.value    = st.acc;
				end
				KIND_M: begin
					res.valid    = 1'b1;
					res.cmd_kind = CMD_MOTOR;
				end
				default: res = '0;
			endcase
		end else if (st.byte_count > CNT_W'(MAX_PAYLOAD)) begin
			// payload overflow: drop the frame
			nxt = FRAME_IDLE;
		end else begin
			if (rx_byte == CH_NUL) begin
				nxt.payload_ended = 1'b1;
			end else if (!st.payload_ended) begin
				nxt.acc = acc_times_ten + digit;
			end
			nxt.byte_count = st.byte_count + CNT_W'(1);
		end
	end

endmodule

// ----- rtl/sscp_checker.sv -----
`timescale 1ns / 1ps

module sscp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  cmd_kind,
	input logic [15:0] value
);
	import sscp_pkg::*;

	// a stalled command holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cmd_kind) && $stable(value))
		else $error("command changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cmd_kind == CMD_WORKING || cmd_kind == CMD_STANDBY ||
			cmd_kind == CMD_MOTOR))
		else $error("bad command kind");

	a_motor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_kind == CMD_MOTOR |-> value == '0)
		else $error("motor toggle carries a value");

	// rx backs up only behind a command the sink is refusing
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("rx stalled without a waiting command");

endmodule

bind serial_setpoint_command_parser_core sscp_checker u_sscp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (rx.ready),
	.out_valid (cmd.valid),
	.out_ready (cmd.ready),
	.cmd_kind  (cmd.cmd_kind),
	.value     (cmd.value)
);
